FILE: rtl/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// shared types and constants of the wav header parser
// ----------------------------------------------------------------------------
package whp_pkg;

  // parse phases, one per header region
  typedef enum logic [3:0] {
    PH_RIFF,
    PH_SIZE,
    PH_WAVE,
    PH_ID1,
    PH_LEN1,
    PH_SKIP1,
    PH_FMTLEN,
    PH_FMT,
    PH_ID2,
    PH_LEN2,
    PH_SKIP2,
    PH_DATALEN
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_RIFF = 2'd1,
    ST_NOT_WAVE = 2'd2,
    ST_TRUNC    = 2'd3
  } status_e;

  // tags as they sit in the little-endian shift window
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BASE_LEN    = 32'd16;
  localparam logic [31:0] FMT_EXT_LEN     = 32'd40;
  localparam logic [15:0] FMT_EXTENSIBLE  = 16'hFFFE;

  typedef struct packed {
    status_e     status;
    logic [15:0] format_tag;
    logic [15:0] subformat_tag;
    logic [15:0] channel_count;
    logic [31:0] frame_rate;
    logic [31:0] byte_rate;
    logic [15:0] frame_bytes;
    logic [15:0] valid_bits;
    logic [12:0] sample_bytes;
    logic [31:0] channel_mask;
    logic [31:0] data_length;
  } hdr_res_t;

endpackage

FILE: rtl/whp_core.sv
// ----------------------------------------------------------------------------
// whp_core
// byte-wise header state machine with fmt field capture
// ----------------------------------------------------------------------------
module whp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_value_i,
  input  logic               start_flag_i,
  input  logic               stream_end_i,
  output logic               res_valid_o,
  output whp_pkg::hdr_res_t  res_o
);
  import whp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] idx_q, idx_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] flen_q, flen_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] frate_q, frate_d;
  logic [31:0] brate_q, brate_d;
  logic [15:0] fbytes_q, fbytes_d;
  logic [15:0] sbits_q, sbits_d;
  logic [15:0] vbits_q, vbits_d;
  logic [15:0] subfmt_q, subfmt_d;
  logic [31:0] mask_q, mask_d;
  logic        fin_q, fin_d;

  logic [31:0] tag_sh;
  logic [31:0] idx_inc;
  logic [31:0] fmt_total;
  logic        four;
  logic        done;
  status_e     err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      idx_q    <= '0;
      tag_q    <= '0;
      clen_q   <= '0;
      flen_q   <= '0;
      fmt_q    <= '0;
      chan_q   <= '0;
      frate_q  <= '0;
      brate_q  <= '0;
      fbytes_q <= '0;
      sbits_q  <= '0;
      vbits_q  <= '0;
      subfmt_q <= '0;
      mask_q   <= '0;
      fin_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      tag_q    <= tag_d;
      clen_q   <= clen_d;
      flen_q   <= flen_d;
      fmt_q    <= fmt_d;
      chan_q   <= chan_d;
      frate_q  <= frate_d;
      brate_q  <= brate_d;
      fbytes_q <= fbytes_d;
      sbits_q  <= sbits_d;
      vbits_q  <= vbits_d;
      subfmt_q <= subfmt_d;
      mask_q   <= mask_d;
      fin_q    <= fin_d;
    end
  end

  always_comb begin
    // a start byte sees the cleared state
    if (start_flag_i) begin
      phase_d  = PH_RIFF;
      idx_d    = '0;
      tag_d    = '0;
      clen_d   = '0;
      flen_d   = '0;
      fmt_d    = '0;
      chan_d   = '0;
      frate_d  = '0;
      brate_d  = '0;
      fbytes_d = '0;
      sbits_d  = '0;
      vbits_d  = '0;
      subfmt_d = '0;
      mask_d   = '0;
      fin_d    = 1'b0;
    end else begin
      phase_d  = phase_q;
      idx_d    = idx_q;
      tag_d    = tag_q;
      clen_d   = clen_q;
      flen_d   = flen_q;
      fmt_d    = fmt_q;
      chan_d   = chan_q;
      frate_d  = frate_q;
      brate_d  = brate_q;
      fbytes_d = fbytes_q;
      sbits_d  = sbits_q;
      vbits_d  = vbits_q;
      subfmt_d = subfmt_q;
      mask_d   = mask_q;
      fin_d    = fin_q;
    end

    err       = ST_OK;
    done      = 1'b0;
    tag_sh    = {byte_value_i, tag_d[31:8]};
    four      = (idx_d == 32'd3);
    idx_inc   = idx_d + 32'd1;
    fmt_total = (flen_d < FMT_BASE_LEN) ? FMT_BASE_LEN : flen_d;

    if (!fin_d) begin
      case (phase_d)
        PH_RIFF, PH_SIZE, PH_WAVE, PH_ID1, PH_ID2, PH_LEN1, PH_LEN2,
        PH_FMTLEN, PH_DATALEN: begin
          tag_d = tag_sh;
          idx_d = four ? '0 : idx_inc;
          if (four) begin
            case (phase_d)
              PH_RIFF: begin
                if (tag_sh != TAG_RIFF) err = ST_NOT_RIFF;
                else phase_d = PH_SIZE;
              end
              PH_SIZE: phase_d = PH_WAVE;
              PH_WAVE: begin
                if (tag_sh != TAG_WAVE) err = ST_NOT_WAVE;
                else phase_d = PH_ID1;
              end
              PH_ID1: phase_d = (tag_sh == TAG_FMT) ? PH_FMTLEN : PH_LEN1;
              PH_ID2: phase_d = (tag_sh == TAG_DATA) ? PH_DATALEN : PH_LEN2;
              PH_LEN1: begin
                clen_d  = tag_sh;
                phase_d = (tag_sh != '0) ? PH_SKIP1 : PH_ID1;
              end
              PH_LEN2: begin
                clen_d  = tag_sh;
                phase_d = (tag_sh != '0) ? PH_SKIP2 : PH_ID2;
              end
              PH_FMTLEN: begin
                flen_d  = tag_sh;
                phase_d = PH_FMT;
              end
              PH_DATALEN: begin
                clen_d = tag_sh;
                done   = 1'b1;
              end
              default: ;
            endcase
          end
        end
        PH_SKIP1, PH_SKIP2: begin
          if (idx_inc >= clen_d) begin
            idx_d   = '0;
            phase_d = (phase_d == PH_SKIP1) ? PH_ID1 : PH_ID2;
          end else begin
            idx_d = idx_inc;
          end
        end
        PH_FMT: begin
          // byte placement by offset within the fmt chunk
          if (idx_d[31:5] == '0) begin
            case (idx_d[4:0])
              5'd0:  fmt_d[7:0]     = byte_value_i;
              5'd1:  fmt_d[15:8]    = byte_value_i;
              5'd2:  chan_d[7:0]    = byte_value_i;
              5'd3:  chan_d[15:8]   = byte_value_i;
              5'd4:  frate_d[7:0]   = byte_value_i;
              5'd5:  frate_d[15:8]  = byte_value_i;
              5'd6:  frate_d[23:16] = byte_value_i;
              5'd7:  frate_d[31:24] = byte_value_i;
              5'd8:  brate_d[7:0]   = byte_value_i;
              5'd9:  brate_d[15:8]  = byte_value_i;
              5'd10: brate_d[23:16] = byte_value_i;
              5'd11: brate_d[31:24] = byte_value_i;
              5'd12: fbytes_d[7:0]  = byte_value_i;
              5'd13: fbytes_d[15:8] = byte_value_i;
              5'd14: sbits_d[7:0]   = byte_value_i;
              5'd15: sbits_d[15:8]  = byte_value_i;
              default: begin
                if (flen_d == FMT_EXT_LEN) begin
                  case (idx_d[4:0])
                    5'd18: vbits_d[7:0]   = byte_value_i;
                    5'd19: vbits_d[15:8]  = byte_value_i;
                    5'd20: mask_d[7:0]    = byte_value_i;
                    5'd21: mask_d[15:8]   = byte_value_i;
                    5'd22: mask_d[23:16]  = byte_value_i;
                    5'd23: mask_d[31:24]  = byte_value_i;
                    5'd24: subfmt_d[7:0]  = byte_value_i;
                    5'd25: subfmt_d[15:8] = byte_value_i;
                    default: ;
                  endcase
                end
              end
            endcase
          end
          if (idx_inc >= fmt_total) begin
            idx_d   = '0;
            phase_d = PH_ID2;
            if (fmt_d != FMT_EXTENSIBLE) begin
              subfmt_d = fmt_d;
              vbits_d  = sbits_d;
            end
          end else begin
            idx_d = idx_inc;
          end
        end
        default: ;
      endcase

      if (!done && err == ST_OK && stream_end_i) err = ST_TRUNC;
      if (done || err != ST_OK) fin_d = 1'b1;
    end
  end

  assign res_valid_o = accept_i && !(start_flag_i ? 1'b0 : fin_q) && fin_d;

  always_comb begin
    res_o        = '0;
    res_o.status = err;
    if (done) begin
      res_o.format_tag    = fmt_d;
      res_o.subformat_tag = subfmt_d;
      res_o.channel_count = chan_d;
      res_o.frame_rate    = frate_d;
      res_o.byte_rate     = brate_d;
      res_o.frame_bytes   = fbytes_d;
      res_o.valid_bits    = vbits_d;
      res_o.sample_bytes  = sbits_d[15:3];
      res_o.channel_mask  = mask_d;
      res_o.data_length   = clen_d;
    end
  end

endmodule

FILE: rtl/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// riff/wave header parser, one file byte per clock unless stalled, one header result per file
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ---------------------------
//   byte in  input      in_valid_i / in_stall_o   byte_value_i, start_flag_i,
//                                                 stream_end_i
//   header   output     out_valid_o / out_stall_i status_o .. data_length_o
//
// one byte request is taken every clock while the result register is free
// or being drained in the same cycle; the header result appears in the cycle
// after the byte that completes it (the last data length byte, a bad tag or
// a byte flagged as stream end)
// the parse state machine updates in the accepting cycle, so a byte is never
// waiting on the one before it
// in_stall_o rises only while a finished result sits unread under out_stall_i
// reset clears the parse state to expect a riff tag and empties the result
// register
//
module wav_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        start_flag_i,
  input  logic        stream_end_i,
  // header results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] format_tag_o,
  output logic [15:0] subformat_tag_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] frame_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] frame_bytes_o,
  output logic [15:0] valid_bits_o,
  output logic [12:0] sample_bytes_o,
  output logic [31:0] channel_mask_o,
  output logic [31:0] data_length_o
);
  import whp_pkg::*;

  logic     accept;
  logic     res_valid;
  hdr_res_t res;
  hdr_res_t res_q;
  logic     out_valid_q;

  // result register is free when empty or when its result leaves this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  whp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_value_i (byte_value_i),
    .start_flag_i (start_flag_i),
    .stream_end_i (stream_end_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign format_tag_o    = res_q.format_tag;
  assign subformat_tag_o = res_q.subformat_tag;
  assign channel_count_o = res_q.channel_count;
  assign frame_rate_o    = res_q.frame_rate;
  assign byte_rate_o     = res_q.byte_rate;
  assign frame_bytes_o   = res_q.frame_bytes;
  assign valid_bits_o    = res_q.valid_bits;
  assign sample_bytes_o  = res_q.sample_bytes;
  assign channel_mask_o  = res_q.channel_mask;
  assign data_length_o   = res_q.data_length;

  // only a held result can push back on the byte side
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("byte side stalled with no result held");

  // error results carry nothing but the status
  a_error_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |->
      (format_tag_o == '0 && data_length_o == '0 && channel_mask_o == '0))
    else $error("error result carries header fields");

  // a plain format reports itself as its subformat
  a_plain_subformat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK && format_tag_o != FMT_EXTENSIBLE) |->
      (subformat_tag_o == format_tag_o))
    else $error("subformat differs from plain format");

endmodule
